[design/svp_pkg.sv]
`timescale 1ns / 1ps

package svp_pkg;

  // Prerelease store sizing
  localparam int PRE_SIZE  = 32;
  localparam int PRE_DEPTH = PRE_SIZE - 1;
  localparam int PRE_AW    = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(PRE_SIZE);

  // Field widths
  localparam int CHAR_W = 8;
  localparam int NUM_W  = 32;
  localparam int LEN_W  = 5;
  localparam int ACC_XW = NUM_W + 4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;

  // Result kinds
  localparam logic KIND_SUM = 1'b0;
  localparam logic KIND_PRE = 1'b1;

  // Summary handed from parser to output stage at the terminator
  typedef struct packed {
    logic             term;
    logic             ok;
    logic [NUM_W-1:0] major;
    logic [NUM_W-1:0] minor;
    logic [NUM_W-1:0] patch;
    logic [CNT_W-1:0] cnt;
  } svp_sum_t;

  // Prerelease store write port
  typedef struct packed {
    logic              we;
    logic [PRE_AW-1:0] addr;
    logic [CHAR_W-1:0] data;
  } svp_wr_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_pre(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           is_digit(c) || (c == CH_DASH) || (c == CH_DOT);
  endfunction

endpackage

[design/svp_in_if.sv]
`timescale 1ns / 1ps

interface svp_in_if
  import svp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

[design/svp_out_if.sv]
`timescale 1ns / 1ps

interface svp_out_if
  import svp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              item_kind;
  logic              valid_res;
  logic [NUM_W-1:0]  major_num;
  logic [NUM_W-1:0]  minor_num;
  logic [NUM_W-1:0]  patch_num;
  logic [LEN_W-1:0]  pre_length;
  logic [CHAR_W-1:0] pre_byte;
  logic              last;

  modport source (output valid, output item_kind, output valid_res, output major_num,
                  output minor_num, output patch_num, output pre_length, output pre_byte,
                  output last, input ready);
  modport sink   (input valid, input item_kind, input valid_res, input major_num,
                  input minor_num, input patch_num, input pre_length, input pre_byte,
                  input last, output ready);
endinterface

[design/svp_ram.sv]
`timescale 1ns / 1ps

module svp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/svp_parse.sv]
`timescale 1ns / 1ps

module svp_parse
  import svp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [CHAR_W-1:0] char_code,
  output svp_wr_t           wr,
  output svp_sum_t          sum
);

  typedef enum logic [9:0] {
    PH_MAJ_START = 10'b0000000001,
    PH_MAJ_DIG   = 10'b0000000010,
    PH_MIN_START = 10'b0000000100,
    PH_MIN_DIG   = 10'b0000001000,
    PH_PAT_START = 10'b0000010000,
    PH_PAT_DIG   = 10'b0000100000,
    PH_PRE_START = 10'b0001000000,
    PH_PRE_BODY  = 10'b0010000000,
    PH_BLD_START = 10'b0100000000,
    PH_BLD_BODY  = 10'b1000000000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [NUM_W-1:0]  major_r, major_nxt;
  logic [NUM_W-1:0]  minor_r, minor_nxt;
  logic [NUM_W-1:0]  patch_r, patch_nxt;
  logic              lz_r, lz_nxt;
  logic              err_r, err_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              dig;
  logic [3:0]        dval;
  logic [NUM_W-1:0]  acc_sel;
  logic [ACC_XW-1:0] acc_ext;
  logic              add_bad;
  logic              pre_full;

  // Shared digit accumulate: acc*10 + d, error after a leading zero or if it spills past 32 bits
  always_comb begin
    dig  = is_digit(char_code);
    dval = char_code[3:0];
    case (phase_r)
      PH_MIN_DIG: acc_sel = minor_r;
      PH_PAT_DIG: acc_sel = patch_r;
      default:    acc_sel = major_r;
    endcase
    acc_ext  = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1) + ACC_XW'(dval);
    add_bad  = lz_r || (|acc_ext[ACC_XW-1:NUM_W]);
    pre_full = (cnt_r == CNT_W'(PRE_DEPTH));
  end

  // Summary seen by the output stage
  always_comb begin
    sum.term  = fire && (char_code == CH_NUL);
    sum.ok    = !err_r && ((phase_r == PH_PAT_DIG) || (phase_r == PH_PRE_BODY) ||
                           (phase_r == PH_BLD_BODY));
    sum.major = major_r;
    sum.minor = minor_r;
    sum.patch = patch_r;
    sum.cnt   = cnt_r;
  end

  // Phase machine
  always_comb begin
    phase_nxt = phase_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    lz_nxt    = lz_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    wr.we     = 1'b0;
    wr.addr   = cnt_r[PRE_AW-1:0];
    wr.data   = char_code;
    if (fire) begin
      if (char_code == CH_NUL) begin
        // terminator: back to the start for the next string
        phase_nxt = PH_MAJ_START;
        major_nxt = '0;
        minor_nxt = '0;
        patch_nxt = '0;
        lz_nxt    = 1'b0;
        err_nxt   = 1'b0;
        cnt_nxt   = '0;
      end else if (!err_r) begin
        case (phase_r)
          PH_MAJ_START, PH_MIN_START, PH_PAT_START: begin
            if (!dig) begin
              err_nxt = 1'b1;
            end else begin
              lz_nxt = (char_code == CH_ZERO);
              if (phase_r == PH_MAJ_START) begin
                major_nxt = NUM_W'(dval);
                phase_nxt = PH_MAJ_DIG;
              end else if (phase_r == PH_MIN_START) begin
                minor_nxt = NUM_W'(dval);
                phase_nxt = PH_MIN_DIG;
              end else begin
                patch_nxt = NUM_W'(dval);
                phase_nxt = PH_PAT_DIG;
              end
            end
          end
          PH_MAJ_DIG: begin
            if (dig) begin
              if (add_bad) err_nxt = 1'b1;
              else major_nxt = acc_ext[NUM_W-1:0];
            end else if (char_code == CH_DOT) begin
              phase_nxt = PH_MIN_START;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_MIN_DIG: begin
            if (dig) begin
              if (add_bad) err_nxt = 1'b1;
              else minor_nxt = acc_ext[NUM_W-1:0];
            end else if (char_code == CH_DOT) begin
              phase_nxt = PH_PAT_START;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_PAT_DIG: begin
            if (dig) begin
              if (add_bad) err_nxt = 1'b1;
              else patch_nxt = acc_ext[NUM_W-1:0];
            end else if (char_code == CH_DASH) begin
              phase_nxt = PH_PRE_START;
            end else if (char_code == CH_PLUS) begin
              phase_nxt = PH_BLD_START;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_PRE_START, PH_PRE_BODY: begin
            if (is_pre(char_code)) begin
              if (pre_full) begin
                err_nxt = 1'b1;
              end else begin
                wr.we     = 1'b1;
                cnt_nxt   = cnt_r + CNT_W'(1);
                phase_nxt = PH_PRE_BODY;
              end
            end else if ((phase_r == PH_PRE_BODY) && (char_code == CH_PLUS)) begin
              phase_nxt = PH_BLD_START;
            end else begin
              err_nxt = 1'b1;
            end
          end
          PH_BLD_START, PH_BLD_BODY: begin
            if (is_pre(char_code)) phase_nxt = PH_BLD_BODY;
            else err_nxt = 1'b1;
          end
          default: err_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAJ_START;
      major_r <= '0;
      minor_r <= '0;
      patch_r <= '0;
      lz_r    <= 1'b0;
      err_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      patch_r <= patch_nxt;
      lz_r    <= lz_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[design/svp_drain.sv]
`timescale 1ns / 1ps

module svp_drain
  import svp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  svp_sum_t          sum,
  input  logic [CHAR_W-1:0] rdata,
  output logic [PRE_AW-1:0] raddr,
  output logic              idle,
  svp_out_if.source         out_ch
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_PRE  = 3'b010,
    D_LAST = 3'b100
  } dstate_t;

  dstate_t           state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              kind_r, kind_nxt;
  logic              vres_r, vres_nxt;
  logic [NUM_W-1:0]  major_r, major_nxt;
  logic [NUM_W-1:0]  minor_r, minor_nxt;
  logic [NUM_W-1:0]  patch_r, patch_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CHAR_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              pre_last;

  // Output register: summary first, then one transaction per stored character
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    vres_nxt  = vres_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    len_nxt   = len_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pre_last  = ((idx_r + CNT_W'(1)) == cnt_r);
    case (state_r)
      D_IDLE: begin
        if (sum.term) begin
          kind_nxt  = KIND_SUM;
          vres_nxt  = sum.ok;
          major_nxt = sum.ok ? sum.major : '0;
          minor_nxt = sum.ok ? sum.minor : '0;
          patch_nxt = sum.ok ? sum.patch : '0;
          len_nxt   = sum.ok ? LEN_W'(sum.cnt) : '0;
          byte_nxt  = '0;
          last_nxt  = !sum.ok || (sum.cnt == '0);
          cnt_nxt   = sum.cnt;
          idx_nxt   = '0;
          state_nxt = (sum.ok && (sum.cnt != '0)) ? D_PRE : D_LAST;
        end
      end
      D_PRE: begin
        if (out_ch.ready) begin
          kind_nxt  = KIND_PRE;
          vres_nxt  = 1'b1;
          major_nxt = '0;
          minor_nxt = '0;
          patch_nxt = '0;
          len_nxt   = '0;
          byte_nxt  = rdata;
          last_nxt  = pre_last;
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = pre_last ? D_LAST : D_PRE;
        end
      end
      D_LAST: begin
        if (out_ch.ready) state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  // Read ahead: memory data always matches the entry idx_r points at
  assign raddr = idx_nxt[PRE_AW-1:0];
  assign idle  = (state_r == D_IDLE);

  assign out_ch.valid      = (state_r != D_IDLE);
  assign out_ch.item_kind  = kind_r;
  assign out_ch.valid_res  = vres_r;
  assign out_ch.major_num  = major_r;
  assign out_ch.minor_num  = minor_r;
  assign out_ch.patch_num  = patch_r;
  assign out_ch.pre_length = len_r;
  assign out_ch.pre_byte   = byte_r;
  assign out_ch.last       = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    vres_r  <= vres_nxt;
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    patch_r <= patch_nxt;
    len_r   <= len_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
  end

endmodule

[design/semver_string_parser_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    char_code[7:0]
// out_ch    out  valid / ready    item_kind, valid_res, major_num, minor_num, patch_num,
//                                 pre_length, pre_byte, last
//
// A non-zero character is accepted every cycle while idle.
// A terminator yields 1 + N results (N stored prerelease characters, 0 if invalid), one per cycle
// while out_ch.ready is high; input is held off until the last of them is taken,
// as the single read port of the prerelease memory is walked one entry a cycle.
// rst_n is synchronous and active low; the prerelease memory needs no clearing.
// Stalls on out_ch hold the current result in the output register.

module semver_string_parser_core
  import svp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  svp_in_if.sink     in_ch,
  svp_out_if.source  out_ch
);

  logic              in_fire;
  logic              drain_idle;
  svp_wr_t           wr;
  svp_sum_t          sum;
  logic [PRE_AW-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  assign in_ch.ready = drain_idle;
  assign in_fire     = in_ch.valid && in_ch.ready;

  svp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .char_code (in_ch.char_code),
    .wr        (wr),
    .sum       (sum)
  );

  // Prerelease character store
  svp_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (PRE_DEPTH)
  ) u_pre_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  svp_drain u_drain (
    .clk    (clk),
    .rst_n  (rst_n),
    .sum    (sum),
    .rdata  (rdata),
    .raddr  (raddr),
    .idle   (drain_idle),
    .out_ch (out_ch)
  );

  // Input is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  // Memory is written only by an accepted transaction
  a_wr_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> in_fire)
    else $error("prerelease write without an accepted transaction");

  // A terminator always presents a result on the next cycle
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.char_code == CH_NUL)) |=> out_ch.valid)
    else $error("no result after terminator");

  // A result that is not the last is followed by another
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("result run ended without last");

endmodule
